// ===== sv/isr_pkg.sv =====
// Shared constants for the integer square root unit.
package isr_pkg;

  // Default radicand width and the fixed width of the root field.
  localparam int unsigned RADICAND_BITS_DEF = 32;
  localparam int unsigned ROOT_BITS         = 16;

  // Exponent of the first trial bit: highest even power below the sign bit.
  function automatic int unsigned top_exp(input int unsigned rad_bits);
    return ((rad_bits - 2) / 2) * 2;
  endfunction

  // Number of cells in the chain, one root bit per cell.
  function automatic int unsigned cell_count(input int unsigned rad_bits);
    return top_exp(rad_bits) / 2 + 1;
  endfunction

endpackage

// ===== sv/isr_cell.sv =====
// One bit-pair restoring step of the square root chain, with its stage register.
module isr_cell #(
  parameter int unsigned WIDTH     = 31,
  parameter int unsigned TRIAL_EXP = 30
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             in_valid,
  input  logic [WIDTH-1:0] in_rem,
  input  logic [WIDTH-1:0] in_root,
  output logic             valid,
  output logic [WIDTH-1:0] rem,
  output logic [WIDTH-1:0] root
);

  localparam logic [WIDTH-1:0] TRIAL = {{(WIDTH-1){1'b0}}, 1'b1} << TRIAL_EXP;

  logic [WIDTH:0]   sum;
  logic             take;
  logic [WIDTH-1:0] rem_next;
  logic [WIDTH-1:0] root_next;

  always_comb begin
    sum       = {1'b0, in_root} + {1'b0, TRIAL};
    take      = {1'b0, in_rem} >= sum;
    rem_next  = take ? (in_rem - sum[WIDTH-1:0]) : in_rem;
    root_next = take ? ((in_root >> 1) + TRIAL) : (in_root >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= in_valid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      rem  <= rem_next;
      root <= root_next;
    end
  end

endmodule

// ===== sv/integer_square_root_unit.sv =====
// Top level of the integer square root unit: stream ports and the chain of cells.
//
// Integer square root, floor(sqrt(radicand)), by the bit-pair restoring method. A signed
// radicand enters on the s_axis channel; zero and negative values give a root of zero. The
// work runs down a chain of RADICAND_BITS/2 cells (16 for a 32-bit radicand), one root bit
// per cell, and each cell registers its partial remainder and root. The length of the chain
// sets the latency. The chain holds one item per cell, so a new transaction can be taken
// each cycle unless every cell is occupied and m_axis is stalled, and items stay in order.
// Stages advance independently: a stall on m_axis fills bubbles first, and s_axis_tready
// drops only once every cell is occupied. The last cell is the output register. For
// radicands wider than 32 bits only the low 16 root bits are returned.
module integer_square_root_unit
  import isr_pkg::*;
#(
  parameter int unsigned RADICAND_BITS = RADICAND_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((RADICAND_BITS+7)/8)*8-1:0]  s_axis_tdata,  // [RADICAND_BITS-1:0] radicand
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [ROOT_BITS-1:0]                m_axis_tdata   // [15:0] root
);

  localparam int unsigned W     = RADICAND_BITS - 1;  // radicand magnitude width
  localparam int unsigned TOP   = top_exp(RADICAND_BITS);
  localparam int unsigned CELLS = cell_count(RADICAND_BITS);

  // Chain taps: index 0 is the input, index k+1 is cell k's register.
  logic         v_c    [CELLS+1];
  logic [W-1:0] rem_c  [CELLS+1];
  logic [W-1:0] root_c [CELLS+1];
  logic         load_c [CELLS+1];

  logic [RADICAND_BITS-1:0] radicand;

  assign radicand = s_axis_tdata[RADICAND_BITS-1:0];

  // Negative radicands enter as zero, which yields a zero root.
  assign v_c[0]    = s_axis_tvalid;
  assign rem_c[0]  = radicand[RADICAND_BITS-1] ? '0 : radicand[W-1:0];
  assign root_c[0] = '0;

  // A cell loads when it is empty or its contents move on this cycle.
  assign load_c[CELLS] = m_axis_tready;

  for (genvar k = CELLS; k > 0; k--) begin : g_ready
    assign load_c[k-1] = !v_c[k] || load_c[k];
  end

  assign s_axis_tready = load_c[0];

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    isr_cell #(
      .WIDTH     (W),
      .TRIAL_EXP (TOP - 2 * k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .load     (load_c[k]),
      .in_valid (v_c[k]),
      .in_rem   (rem_c[k]),
      .in_root  (root_c[k]),
      .valid    (v_c[k+1]),
      .rem      (rem_c[k+1]),
      .root     (root_c[k+1])
    );
  end

  assign m_axis_tvalid = v_c[CELLS];
  assign m_axis_tdata  = ROOT_BITS'(root_c[CELLS]);

`ifndef SYNTHESIS
  // Final remainder is radicand - root^2, which stays at or below 2*root.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ({1'b0, rem_c[CELLS]} <= {root_c[CELLS], 1'b0}))
    else $error("square root remainder out of range");

  // An empty first cell always takes a transaction.
  a_head_ready: assert property (@(posedge clk) disable iff (rst)
    !v_c[1] |-> s_axis_tready)
    else $error("chain head empty but input stalled");

  // The output cell holds its result while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result lost or changed");

  // Reset empties the chain.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !v_c[1])
    else $error("chain not empty after reset");
`endif

endmodule
